// ----- sv/sfch_pkg.sv -----
package sfch_pkg;

  localparam int unsigned CMD_FIFO_DEPTH = 4;
  localparam int unsigned CMD_PTR_W      = $clog2(CMD_FIFO_DEPTH);

  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SESSION_ENABLED = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ERASE_ADDR      = 1'b1;

  localparam logic [7:0] FRAME_START  = 8'h55;
  localparam logic [7:0] FRAME_END    = 8'hCC;
  localparam logic [7:0] OP_HELLO     = 8'd1;
  localparam logic [7:0] OP_WRITE     = 8'd3;
  localparam logic [7:0] OP_STATUS    = 8'd100;
  localparam logic [7:0] MIN_WRITE_LEN = 8'd4;
  localparam logic [7:0] STATUS_LEN   = 8'd25;

  localparam logic [1:0] RES_TX    = 2'd0;
  localparam logic [1:0] RES_ERASE = 2'd1;
  localparam logic [1:0] RES_WRITE = 2'd2;

  // Position of the last result of each reply burst.
  localparam logic [4:0] SHORT_LAST_IDX  = 5'd3;
  localparam logic [4:0] STATUS_LAST_IDX = 5'd28;
  localparam logic [4:0] STATUS_TEXT_OFS = 5'd3;

  localparam logic [7:0] STATUS_TEXT [25] = '{
    8'h6F, 8'h70, 8'h63, 8'h6F, 8'h64, 8'h65, 8'h20, 8'h31, 8'h30, 8'h30,
    8'h3A, 8'h20, 8'h63, 8'h75, 8'h72, 8'h72, 8'h65, 8'h6E, 8'h20, 8'h53,
    8'h74, 8'h61, 8'h74, 8'h65, 8'h2E
  };

  typedef enum logic [2:0] {
    PH_STOPPED = 3'b001,
    PH_AWAIT   = 3'b010,
    PH_ACTIVE  = 3'b100
  } phase_e;

  typedef enum logic [1:0] {
    CMD_ERASE  = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_SHORT  = 2'd2,
    CMD_STATUS = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e        kind;
    logic [31:0] addr;
    logic [7:0]  data;
  } cmd_t;

  typedef struct packed {
    logic                 we;
    logic [CFG_IDX_W-1:0] index;
    logic [31:0]          wdata;
  } cfg_t;

  function automatic logic [7:0] status_char(input logic [4:0] idx);
    logic [7:0] c;
    c = 8'h00;
    if (idx < 5'd25) begin
      c = STATUS_TEXT[idx];
    end
    return c;
  endfunction

endpackage

// ----- sv/sfch_if.sv -----
interface sfch_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfch_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [31:0] flash_address;
  logic [7:0]  data_byte;
  logic        last_of_run;

  modport source (output valid, output result_kind, output flash_address,
                  output data_byte, output last_of_run, input ready);
  modport sink (input valid, input result_kind, input flash_address,
                input data_byte, input last_of_run, output ready);
endinterface

// ----- sv/sfch_front.sv -----
module sfch_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sfch_pkg::cfg_t cfg_i,
  sfch_rx_if.sink       rx_i,
  input  logic          full_i,
  output logic          push_o,
  output sfch_pkg::cmd_t cmd_o
);
  import sfch_pkg::*;

  phase_e      phase_q, phase_d;
  logic [8:0]  pos_q, pos_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  op_q, op_d;
  logic [31:0] wp_q, wp_d;
  logic [31:0] erase_addr_q, erase_addr_d;

  logic        acc;
  logic [7:0]  b;
  logic [31:0] wp_shift;
  logic [8:0]  end_pos;

  assign rx_i.ready = !full_i;
  assign acc        = rx_i.valid && !full_i;
  assign b          = rx_i.rx_byte;
  assign end_pos    = {1'b0, len_q} + 9'd3;
  assign wp_shift   = (pos_q <= 9'd6) ? {wp_q[23:0], b} : wp_q;

  always_comb begin
    phase_d      = phase_q;
    pos_d        = pos_q;
    len_d        = len_q;
    op_d         = op_q;
    wp_d         = wp_q;
    erase_addr_d = erase_addr_q;
    push_o       = 1'b0;
    cmd_o.kind   = CMD_SHORT;
    cmd_o.addr   = 32'd0;
    cmd_o.data   = op_q;

    if (cfg_i.we) begin
      if (cfg_i.index == CFG_SESSION_ENABLED) begin
        phase_d = cfg_i.wdata[0] ? PH_AWAIT : PH_STOPPED;
        pos_d   = 9'd0;
        len_d   = 8'd0;
        op_d    = 8'd0;
        wp_d    = 32'd0;
      end else begin
        erase_addr_d = cfg_i.wdata;
      end
    end else if (acc && phase_q != PH_STOPPED) begin
      if (pos_q == 9'd0) begin
        if (b == FRAME_START) begin
          pos_d = 9'd1;
        end
      end else if (pos_q == 9'd1) begin
        len_d = b;
        pos_d = 9'd2;
      end else if (pos_q == 9'd2) begin
        op_d  = b;
        pos_d = 9'd3;
      end else if (pos_q >= end_pos) begin
        // Trailer byte: the frame is complete.
        pos_d = 9'd0;
        if (phase_q == PH_AWAIT) begin
          if (op_q == OP_HELLO) begin
            phase_d = PH_ACTIVE;
          end
        end else if (phase_q == PH_ACTIVE) begin
          push_o     = 1'b1;
          cmd_o.kind = (op_q == OP_STATUS) ? CMD_STATUS : CMD_SHORT;
        end
      end else begin
        wp_d = wp_shift;
        if (phase_q == PH_ACTIVE && op_q == OP_WRITE && len_q >= MIN_WRITE_LEN) begin
          if (pos_q == 9'd6 && wp_shift == 32'd0) begin
            push_o     = 1'b1;
            cmd_o.kind = CMD_ERASE;
            cmd_o.addr = erase_addr_q;
            cmd_o.data = 8'd0;
          end
          if (pos_q >= 9'd7) begin
            push_o     = 1'b1;
            cmd_o.kind = CMD_WRITE;
            cmd_o.addr = wp_shift;
            cmd_o.data = b;
            wp_d       = wp_shift + 32'd1;
          end
        end
        pos_d = pos_q + 9'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_STOPPED;
      pos_q        <= 9'd0;
      len_q        <= 8'd0;
      op_q         <= 8'd0;
      wp_q         <= 32'd0;
      erase_addr_q <= 32'd0;
    end else begin
      phase_q      <= phase_d;
      pos_q        <= pos_d;
      len_q        <= len_d;
      op_q         <= op_d;
      wp_q         <= wp_d;
      erase_addr_q <= erase_addr_d;
    end
  end

endmodule

// ----- sv/sfch_cmd_fifo.sv -----
module sfch_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sfch_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output sfch_pkg::cmd_t cmd_o
);
  import sfch_pkg::*;

  cmd_t                 mem_q [CMD_FIFO_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [CMD_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CMD_PTR_W:0]   count_q, count_d;
  logic                 do_push, do_pop;

  assign full_o  = (count_q == (CMD_PTR_W + 1)'(CMD_FIFO_DEPTH));
  assign valid_o = (count_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = wr_ptr_q + CMD_PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + CMD_PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + (CMD_PTR_W + 1)'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - (CMD_PTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ----- sv/sfch_back.sv -----
module sfch_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  sfch_pkg::cmd_t cmd_i,
  output logic           pop_o,
  sfch_res_if.source     res_o
);
  import sfch_pkg::*;

  logic [4:0]  idx_q, idx_d;
  logic        out_valid_q, out_valid_d;
  logic [1:0]  kind_q, kind_d;
  logic [31:0] addr_q, addr_d;
  logic [7:0]  data_q, data_d;
  logic        last_q, last_d;

  logic        can_load;
  logic [1:0]  r_kind;
  logic [31:0] r_addr;
  logic [7:0]  r_data;
  logic        r_last;

  assign can_load = !out_valid_q || res_o.ready;

  // Expand the head command into the result at position idx_q of its run.
  always_comb begin
    r_kind = RES_TX;
    r_addr = 32'd0;
    r_data = 8'd0;
    r_last = 1'b1;
    case (cmd_i.kind)
      CMD_ERASE: begin
        r_kind = RES_ERASE;
        r_addr = cmd_i.addr;
      end
      CMD_WRITE: begin
        r_kind = RES_WRITE;
        r_addr = cmd_i.addr;
        r_data = cmd_i.data;
      end
      CMD_SHORT: begin
        r_last = (idx_q == SHORT_LAST_IDX);
        case (idx_q)
          5'd0:    r_data = FRAME_START;
          5'd1:    r_data = 8'd0;
          5'd2:    r_data = cmd_i.data;
          default: r_data = FRAME_END;
        endcase
      end
      default: begin
        r_last = (idx_q == STATUS_LAST_IDX);
        case (idx_q)
          5'd0:            r_data = FRAME_START;
          5'd1:            r_data = STATUS_LEN;
          5'd2:            r_data = OP_STATUS;
          STATUS_LAST_IDX: r_data = FRAME_END;
          default:         r_data = status_char(idx_q - STATUS_TEXT_OFS);
        endcase
      end
    endcase
  end

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    kind_d      = kind_q;
    addr_d      = addr_q;
    data_d      = data_q;
    last_d      = last_q;
    pop_o       = 1'b0;
    if (can_load) begin
      out_valid_d = valid_i;
      if (valid_i) begin
        kind_d = r_kind;
        addr_d = r_addr;
        data_d = r_data;
        last_d = r_last;
        if (r_last) begin
          pop_o = 1'b1;
          idx_d = 5'd0;
        end else begin
          idx_d = idx_q + 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 5'd0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    addr_q <= addr_d;
    data_q <= data_d;
    last_q <= last_d;
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.result_kind   = kind_q;
  assign res_o.flash_address = addr_q;
  assign res_o.data_byte     = data_q;
  assign res_o.last_of_run   = last_q;

endmodule

// ----- sv/serial_frame_command_handler.sv -----
// Results of a byte pass through the command queue, then are registered in the output stage.
// Throughput: one byte per cycle while the four-entry command queue has room.
// The result stage emits one result per cycle unless the output is stalled: a write or erase
// is one result, a short reply four results and the status reply 29 results.
// Reset (asynchronous, active low) stops the session and empties the queue and output stage.
module serial_frame_command_handler (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sfch_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [31:0]                       cfg_wdata_i,
  sfch_rx_if.sink                           rx_i,
  sfch_res_if.source                        res_o
);
  import sfch_pkg::*;

  cfg_t cfg;
  logic push, full, pop, head_valid;
  cmd_t push_cmd, head_cmd;

  assign cfg.we    = cfg_we_i;
  assign cfg.index = cfg_index_i;
  assign cfg.wdata = cfg_wdata_i;

  sfch_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .rx_i   (rx_i),
    .full_i (full),
    .push_o (push),
    .cmd_o  (push_cmd)
  );

  sfch_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .cmd_o   (head_cmd)
  );

  sfch_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (head_valid),
    .cmd_i   (head_cmd),
    .pop_o   (pop),
    .res_o   (res_o)
  );

endmodule

// ----- test/serial_frame_command_handler_test.sv -----
`timescale 1ns / 1ps

module serial_frame_command_handler_test;
  import sfch_pkg::*;

  localparam string STATUS_LINE = "opcode 100: curren State.";
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] addr;
    logic [7:0]  data;
    logic        last;
  } result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_wdata = '0;
  logic rx_valid = 1'b0;
  logic [7:0] rx_data = 8'h00;
  logic res_ready = 1'b0;
  logic rx_fire = 1'b0;

  sfch_rx_if rx_if ();
  sfch_res_if res_if ();

  assign rx_if.valid = rx_valid;
  assign rx_if.rx_byte = rx_data;
  assign res_if.ready = res_ready;

  serial_frame_command_handler u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata),
    .rx_i        (rx_if),
    .res_o       (res_if)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Predicted state of the handler.
  phase_e      sess_phase = PH_STOPPED;
  logic [8:0]  frame_pos = '0;
  logic [7:0]  frame_len = '0;
  logic [7:0]  frame_op = '0;
  logic [31:0] flash_ptr = '0;
  logic [31:0] erase_sector = '0;

  logic [7:0] pending_rx[$];
  result_t    predicted_out[$];
  int bytes_queued = 0;
  int bytes_taken = 0;
  int fail_count = 0;

  function automatic result_t tx_result(input logic [7:0] d);
    return '{RES_TX, 32'h0, d, 1'b0};
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    if (idx == CFG_SESSION_ENABLED) begin
      sess_phase = val[0] ? PH_AWAIT : PH_STOPPED;
      frame_pos = '0;
      frame_len = '0;
      frame_op = '0;
      flash_ptr = '0;
    end else begin
      erase_sector = val;
    end
  endfunction

  function automatic void parse_byte(input logic [7:0] b);
    result_t run[$];
    if (sess_phase == PH_STOPPED) begin
    end else if (frame_pos == 9'd0) begin
      if (b == FRAME_START) frame_pos = 9'd1;
    end else if (frame_pos == 9'd1) begin
      frame_len = b;
      frame_pos = 9'd2;
    end else if (frame_pos == 9'd2) begin
      frame_op = b;
      frame_pos = 9'd3;
    end else if (frame_pos >= {1'b0, frame_len} + 9'd3) begin
      frame_pos = '0;
      if (sess_phase == PH_AWAIT) begin
        if (frame_op == OP_HELLO) sess_phase = PH_ACTIVE;
      end else begin
        run.push_back(tx_result(FRAME_START));
        if (frame_op == OP_STATUS) begin
          run.push_back(tx_result(STATUS_LEN));
          run.push_back(tx_result(OP_STATUS));
          for (int i = 0; i < 25; i++) run.push_back(tx_result(STATUS_LINE[i]));
        end else begin
          run.push_back(tx_result(8'h00));
          run.push_back(tx_result(frame_op));
        end
        run.push_back(tx_result(FRAME_END));
      end
    end else begin
      // The first four payload bytes build the big-endian flash address.
      if (frame_pos <= 9'd6) flash_ptr = {flash_ptr[23:0], b};
      if (sess_phase == PH_ACTIVE && frame_op == OP_WRITE && frame_len >= MIN_WRITE_LEN) begin
        if (frame_pos == 9'd6 && flash_ptr == 32'h0) begin
          run.push_back('{RES_ERASE, erase_sector, 8'h00, 1'b0});
        end
        if (frame_pos >= 9'd7) begin
          run.push_back('{RES_WRITE, flash_ptr, b, 1'b0});
          flash_ptr = flash_ptr + 32'd1;
        end
      end
      frame_pos = frame_pos + 9'd1;
    end
    if (run.size() != 0) run[run.size() - 1].last = 1'b1;
    foreach (run[i]) predicted_out.push_back(run[i]);
  endfunction

  // Sender: bursts of random length separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;

  always @(negedge clk_i) begin
    if (!rx_valid || rx_fire) begin
      if (gap_left != 0) begin
        gap_left--;
        rx_valid <= 1'b0;
      end else if (pending_rx.size() == 0) begin
        rx_valid <= 1'b0;
      end else begin
        rx_valid <= 1'b1;
        rx_data <= pending_rx.pop_front();
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 20);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    rx_fire <= rx_valid && rx_if.ready;
    if (rx_valid && rx_if.ready) begin
      parse_byte(rx_data);
      bytes_taken <= bytes_taken + 1;
    end
  end

  // Receiver: a rotating ready pattern, reselected each time stall_left runs out.
  logic [15:0] stall_pat = 16'hFFFF;
  int stall_left = 0;

  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_left = 64;
      case ($urandom_range(0, 2))
        0:       stall_pat = 16'hFFFF;
        1:       stall_pat = 16'($urandom) | 16'h0001;
        default: stall_pat = 16'($urandom) | 16'h0101;
      endcase
    end
    stall_left--;
    res_ready <= stall_pat[0];
    stall_pat = {stall_pat[0], stall_pat[15:1]};
  end

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (res_if.valid && res_ready) begin
      got = '{res_if.result_kind, res_if.flash_address, res_if.data_byte, res_if.last_of_run};
      if (predicted_out.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("%0t: unexpected result kind %0d addr %h data %h last %b",
                   $realtime, got.kind, got.addr, got.data, got.last);
        end
      end else begin
        want = predicted_out.pop_front();
        if (got.kind !== want.kind || got.addr !== want.addr || got.data !== want.data ||
            got.last !== want.last) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("%0t: expected kind %0d addr %h data %h last %b, got kind %0d addr %h data %h last %b",
                     $realtime, want.kind, want.addr, want.data, want.last,
                     got.kind, got.addr, got.data, got.last);
          end
        end
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    apply_reg(idx, val);
  endtask

  task automatic queue_byte(input logic [7:0] b);
    pending_rx.push_back(b);
    bytes_queued++;
  endtask

  task automatic queue_frame(input logic [7:0] op, input logic [7:0] len,
                             input logic [31:0] addr);
    queue_byte(FRAME_START);
    queue_byte(len);
    queue_byte(op);
    for (int i = 0; i < len; i++) queue_byte(i < 4 ? addr[31 - 8 * i -: 8] : 8'($urandom));
    queue_byte(8'($urandom));
  endtask

  task automatic queue_random_frame();
    int roll;
    logic [31:0] addr;
    roll = $urandom_range(0, 99);
    addr = $urandom;
    if ($urandom_range(0, 3) == 0) addr = 32'h0;
    else if ($urandom_range(0, 5) == 0) addr = 32'hFFFF_FFFF - $urandom_range(0, 3);
    if (roll < 8) begin
      queue_frame(OP_HELLO, 8'($urandom_range(0, 3)), addr);
    end else if (roll < 50) begin
      if ($urandom_range(0, 4) == 0) queue_frame(OP_WRITE, 8'($urandom_range(0, 3)), addr);
      else queue_frame(OP_WRITE, 8'($urandom_range(4, 12)), addr);
    end else if (roll < 62) begin
      queue_frame(OP_STATUS, 8'($urandom_range(0, 3)), addr);
    end else if (roll < 80) begin
      queue_frame(8'($urandom), 8'($urandom_range(0, 6)), addr);
    end else if (roll < 90) begin
      repeat ($urandom_range(1, 4)) queue_byte(8'($urandom));
    end else begin
      // A frame cut off after its length; following bytes fall into its payload.
      queue_byte(FRAME_START);
      queue_byte(8'($urandom_range(0, 8)));
    end
  endtask

  // Waits until every byte is taken and every predicted result has come out,
  // then leaves time for bytes that cause no result to drain.
  task automatic settle();
    while (bytes_taken != bytes_queued || predicted_out.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int start;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    write_reg(CFG_ERASE_ADDR, 32'hFFFF_FFFF);
    write_reg(CFG_SESSION_ENABLED, 32'd0);
    queue_byte(FRAME_START);
    queue_byte(8'h00);
    settle();

    write_reg(CFG_SESSION_ENABLED, 32'd1);
    queue_byte(8'h00);
    queue_frame(8'd2, 8'd0, 32'h0);
    queue_frame(OP_HELLO, 8'd0, 32'h0);
    queue_frame(OP_WRITE, 8'd5, 32'h0);
    queue_frame(OP_STATUS, 8'd0, 32'h0);
    queue_frame(OP_WRITE, 8'd2, 32'h0);
    settle();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       write_reg(CFG_ERASE_ADDR, 32'h0);
        2:       write_reg(CFG_ERASE_ADDR, 32'hFFFF_FFFF);
        default: write_reg(CFG_ERASE_ADDR, $urandom);
      endcase
      if (ph == 2) begin
        write_reg(CFG_SESSION_ENABLED, 32'd0);
        queue_frame(OP_HELLO, 8'd0, 32'h0);
        queue_frame(OP_STATUS, 8'd1, 32'h0);
        settle();
      end
      // The first phase restarts a session that is already active.
      write_reg(CFG_SESSION_ENABLED, 32'd1);
      start = bytes_queued;
      if (ph == 0 || $urandom_range(0, 3) != 0) queue_frame(OP_HELLO, 8'd0, 32'h0);
      if (ph == 0) queue_frame(OP_WRITE, 8'd8, 32'hFFFF_FFFE);
      if (ph == 1) queue_frame(OP_WRITE, 8'd255, $urandom);
      while (bytes_queued - start < 20) queue_random_frame();
      settle();
    end

    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
